[sv/pcsm_pkg.sv]
// package: machine sizes, opcodes, opr codes, and sequencer state type for the p-code machine
`default_nettype none
package pcsm_pkg;
  localparam int STACK_DEPTH = 4096;
  localparam int CODE_DEPTH  = 2048;
  localparam int MAX_LEVEL   = 3;
  localparam int DATA_WIDTH  = 32;

  localparam logic [2:0] OP_LIT = 3'd0;
  localparam logic [2:0] OP_OPR = 3'd1;
  localparam logic [2:0] OP_LOD = 3'd2;
  localparam logic [2:0] OP_STO = 3'd3;
  localparam logic [2:0] OP_CAL = 3'd4;
  localparam logic [2:0] OP_INT = 3'd5;
  localparam logic [2:0] OP_JMP = 3'd6;
  localparam logic [2:0] OP_JPC = 3'd7;

  localparam logic [10:0] OPR_RET = 11'd0;
  localparam logic [10:0] OPR_NEG = 11'd1;
  localparam logic [10:0] OPR_ADD = 11'd2;
  localparam logic [10:0] OPR_SUB = 11'd3;
  localparam logic [10:0] OPR_MUL = 11'd4;
  localparam logic [10:0] OPR_DIV = 11'd5;
  localparam logic [10:0] OPR_ODD = 11'd6;
  localparam logic [10:0] OPR_EQ  = 11'd8;
  localparam logic [10:0] OPR_NE  = 11'd9;
  localparam logic [10:0] OPR_LT  = 11'd10;
  localparam logic [10:0] OPR_GE  = 11'd11;
  localparam logic [10:0] OPR_GT  = 11'd12;
  localparam logic [10:0] OPR_LE  = 11'd13;

  localparam int OPCODE_W  = 3;
  localparam int LEVEL_W   = 2;
  localparam int OPERAND_W = 11;
  localparam int PC_OUT_W  = 11;
  localparam int BASE_OUT_W = 12;
  localparam int TOP_OUT_W = 13;
  localparam int VAL_OUT_W = 32;

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_WALK  = 14'b00000000000100,
    S_WWAIT = 14'b00000000001000,
    S_RD1   = 14'b00000000010000,
    S_RD2   = 14'b00000000100000,
    S_RWAIT = 14'b00000001000000,
    S_EXEC  = 14'b00000010000000,
    S_DIV   = 14'b00000100000000,
    S_WR    = 14'b00001000000000,
    S_WR2   = 14'b00010000000000,
    S_TOPRD = 14'b00100000000000,
    S_TOPW  = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } seq_state_t;
endpackage
`default_nettype wire

[sv/pcsm_ram.sv]
// generic single port ram with registered read
`default_nettype none
module pcsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[sv/pcsm_alu.sv]
// shared alu: add, sub, mul, compare, and a one-bit-per-cycle signed divider
`default_nettype none
module pcsm_alu #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [10:0]           code,
  input  wire logic [DATA_WIDTH-1:0] x,
  input  wire logic [DATA_WIDTH-1:0] y,
  output logic      [DATA_WIDTH-1:0] res,
  output logic                       busy,
  output logic                       dz
);
  import pcsm_pkg::*;
  localparam int CW = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH-1:0] q_r, q_nxt, rem_r, rem_nxt, dv_r, dv_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic neg_r, neg_nxt, busy_r, busy_nxt;
  logic [DATA_WIDTH-1:0] ax, ay, mulr;
  logic [DATA_WIDTH:0] trial;
  logic [DATA_WIDTH-1:0] shl;
  logic sx, sy, lt;

  assign sx = x[DATA_WIDTH-1];
  assign sy = y[DATA_WIDTH-1];
  assign ax = sx ? (~x + 1'b1) : x;
  assign ay = sy ? (~y + 1'b1) : y;
  assign mulr = x * y;
  assign lt = $signed(x) < $signed(y);
  assign dz = (y == '0);
  assign shl = {rem_r[DATA_WIDTH-2:0], q_r[DATA_WIDTH-1]};
  assign trial = {1'b0, shl} - {1'b0, dv_r};
  assign busy = busy_r;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    dv_nxt = dv_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt = ax;
      rem_nxt = '0;
      dv_nxt = ay;
      cnt_nxt = CW'(DATA_WIDTH);
      neg_nxt = sx ^ sy;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r[DATA_WIDTH-1] || !trial[DATA_WIDTH]) begin
        rem_nxt = {rem_r[DATA_WIDTH-2:0], q_r[DATA_WIDTH-1]} - dv_r;
        q_nxt = {q_r[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = shl;
        q_nxt = {q_r[DATA_WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    dv_r <= dv_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_comb begin
    case (code)
      OPR_ADD: res = x + y;
      OPR_SUB: res = x - y;
      OPR_MUL: res = mulr;
      OPR_DIV: res = dz ? '0 : (neg_r ? (~q_r + 1'b1) : q_r);
      OPR_EQ:  res = DATA_WIDTH'(x == y);
      OPR_NE:  res = DATA_WIDTH'(x != y);
      OPR_LT:  res = DATA_WIDTH'(lt);
      OPR_GE:  res = DATA_WIDTH'(!lt);
      OPR_GT:  res = DATA_WIDTH'(!lt && (x != y));
      default: res = DATA_WIDTH'(lt || (x == y));
    endcase
  end
endmodule
`default_nettype wire

[sv/pcode_stack_machine_exec.sv]
// top level: p-code sequencer around the data stack ram and the shared alu
//
// channel | dir | payload
// in_*    | in  | opcode, level, operand
// out_*   | out | next_pc, base_index, top_index, top_value, halted, fault
//
// after reset a clearing pass writes zero to every stack word before idle
// an item with one stack read passes S_WALK, S_RD1, S_RWAIT, S_EXEC, S_WR, S_TOPRD, S_TOPW and S_OUT
// a second stack read adds S_RD2 and S_RWAIT, each static link S_WALK and S_WWAIT, cal S_WR2 for its extra writes
// divide waits in S_DIV while the shared alu is busy
// in_tready is high in idle; a new result waits in S_OUT while the last one is held
// the result sits in an output register until out_tready
`default_nettype none
module pcode_stack_machine_exec (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // opcode[2:0], level[4:3], operand[15:5]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // next_pc, base_index, top_index, top_value,
                                       // halted, fault, zero pad
  output logic             out_tuser
);
  import pcsm_pkg::*;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(CODE_DEPTH);
  localparam int IW = (AW > DATA_WIDTH ? AW : DATA_WIDTH) + 3;
  localparam int LW = $clog2(MAX_LEVEL + 1) + 1;

  seq_state_t st_r, st_nxt;
  logic [PW-1:0] pc_r, pc_nxt;
  logic [AW-1:0] b_r, b_nxt;
  logic signed [AW+1:0] t_r, t_nxt;
  logic [2:0] op_r, op_nxt;
  logic [10:0] a_r, a_nxt;
  logic [LW-1:0] lv_r, lv_nxt;
  logic signed [IW-1:0] wb_r, wb_nxt;
  logic [DATA_WIDTH-1:0] x_r, x_nxt, y_r, y_nxt, r_r, r_nxt;
  logic f_r, f_nxt, ov_r, ov_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [AW:0] clr_r, clr_nxt;
  logic [71:0] od_r, od_nxt;

  logic we;
  logic [AW-1:0] addr;
  logic [DATA_WIDTH-1:0] wdata, rdata, alu_res;
  logic alu_start, alu_busy, alu_dz;

  pcsm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STACK_DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  pcsm_alu #(.DATA_WIDTH(DATA_WIDTH)) u_alu (
    .clk(clk), .rst_n(rst_n), .start(alu_start), .code(a_r), .x(x_r), .y(y_r),
    .res(alu_res), .busy(alu_busy), .dz(alu_dz)
  );

  function automatic logic inr(input logic signed [IW-1:0] i);
    inr = (i >= 0) && (i < IW'(STACK_DEPTH));
  endfunction

  function automatic logic signed [IW-1:0] sxd(input logic [DATA_WIDTH-1:0] d);
    sxd = IW'($signed(d));
  endfunction

  logic signed [IW-1:0] t0, b0, tgt;
  logic [DATA_WIDTH-1:0] rd_v;
  logic signed [IW-1:0] rd_i;
  logic signed [IW-1:0] newtop;
  logic wr_ok;

  assign t0 = IW'(t_r);
  assign b0 = IW'({1'b0, b_r});
  assign in_tready = st_r == S_IDLE;
  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
  assign out_tuser = 1'b0;

  always_comb begin
    st_nxt = st_r; pc_nxt = pc_r; b_nxt = b_r; t_nxt = t_r;
    op_nxt = op_r; a_nxt = a_r; lv_nxt = lv_r; wb_nxt = wb_r;
    x_nxt = x_r; y_nxt = y_r; r_nxt = r_r; f_nxt = f_r;
    ov_nxt = ov_r; ph_nxt = ph_r; clr_nxt = clr_r;
    od_nxt = od_r;
    we = 1'b0; addr = '0; wdata = '0; alu_start = 1'b0;
    rd_i = '0; tgt = '0; newtop = t0; wr_ok = 1'b0; rd_v = '0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (st_r)
      S_CLEAR: begin
        we = 1'b1;
        addr = clr_r[AW-1:0];
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (AW+1)'(STACK_DEPTH - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          op_nxt = in_tdata[2:0];
          lv_nxt = (in_tdata[4:3] > 2'(MAX_LEVEL)) ? LW'(MAX_LEVEL) : LW'(in_tdata[4:3]);
          a_nxt = in_tdata[15:5];
          f_nxt = 1'b0;
          pc_nxt = pc_r + 1'b1;
          wb_nxt = b0;
          ph_nxt = 2'd0;
          st_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if ((op_r == OP_LOD || op_r == OP_STO || op_r == OP_CAL) && lv_r != '0) begin
          if (inr(wb_r)) begin
            addr = wb_r[AW-1:0];
            st_nxt = S_WWAIT;
          end else begin
            f_nxt = 1'b1;
            wb_nxt = '0;
            lv_nxt = lv_r - 1'b1;
          end
        end else begin
          ph_nxt = 2'd0;
          st_nxt = S_RD1;
        end
      end
      S_WWAIT: begin
        wb_nxt = sxd(rdata);
        lv_nxt = lv_r - 1'b1;
        st_nxt = S_WALK;
      end
      S_RD1, S_RD2: begin
        // x gets first read, y second
        case (op_r)
          OP_OPR: begin
            if (a_r == OPR_RET) rd_i = (st_r == S_RD1) ? b0 + 2 : b0 + 1;
            else if (a_r == OPR_NEG || a_r == OPR_ODD) rd_i = t0;
            else rd_i = (st_r == S_RD1) ? t0 - 1 : t0;
          end
          OP_LOD: rd_i = inr(wb_r) ? wb_r + IW'(a_r) : IW'(-1);
          default: rd_i = t0;
        endcase
        if (inr(rd_i)) begin
          addr = rd_i[AW-1:0];
          st_nxt = S_RWAIT;
        end else begin
          if (op_r == OP_OPR || op_r == OP_LOD || op_r == OP_STO || op_r == OP_JPC)
            f_nxt = (op_r == OP_OPR && !(a_r == OPR_RET || a_r == OPR_NEG || a_r == OPR_ODD
                     || (a_r >= OPR_ADD && a_r <= OPR_DIV) || (a_r >= OPR_EQ && a_r <= OPR_LE)))
                    ? f_r : 1'b1;
          if (st_r == S_RD1) x_nxt = '0; else y_nxt = '0;
          st_nxt = S_RWAIT;
          // low bit marks a read that was out of range
          ph_nxt = (st_r == S_RD1) ? 2'd1 : 2'd3;
        end
      end
      S_RWAIT: begin
        rd_v = ph_r[0] ? '0 : rdata;
        if (ph_r[1] == 1'b0) begin
          x_nxt = rd_v;
          ph_nxt = 2'd2;
          if (op_r == OP_OPR && (a_r == OPR_RET || (a_r >= OPR_ADD && a_r <= OPR_DIV)
              || (a_r >= OPR_EQ && a_r <= OPR_LE)))
            st_nxt = S_RD2;
          else
            st_nxt = S_EXEC;
        end else begin
          y_nxt = rd_v;
          ph_nxt = 2'd0;
          st_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        st_nxt = S_WR;
        case (op_r)
          OP_OPR: begin
            if (a_r == OPR_DIV) begin
              if (alu_dz) f_nxt = 1'b1;
              alu_start = 1'b1;
              st_nxt = S_DIV;
            end
          end
          default: ;
        endcase
      end
      S_DIV: begin
        if (!alu_busy) st_nxt = S_WR;
      end
      S_WR: begin
        st_nxt = S_TOPRD;
        case (op_r)
          OP_LIT: begin
            tgt = t0 + 1; wdata = DATA_WIDTH'(a_r); wr_ok = 1'b1; newtop = t0 + 1;
          end
          OP_LOD: begin
            tgt = t0 + 1; wdata = x_r; wr_ok = 1'b1; newtop = t0 + 1;
          end
          OP_STO: begin
            tgt = inr(wb_r) ? wb_r + IW'(a_r) : IW'(-1);
            wdata = x_r; wr_ok = 1'b1; newtop = t0 - 1;
          end
          OP_CAL: begin
            tgt = t0 + 1; wdata = DATA_WIDTH'(wb_r); wr_ok = 1'b1;
            st_nxt = S_WR2; ph_nxt = 2'd0;
          end
          OP_INT: newtop = t0 + IW'(a_r);
          OP_JMP: pc_nxt = a_r[PW-1:0];
          OP_JPC: begin
            if (x_r != '0) pc_nxt = PW'(a_r);
            newtop = t0 - 1;
          end
          default: begin
            if (a_r == OPR_RET) begin
              newtop = b0 - 1;
              pc_nxt = x_r[PW-1:0];
              if (sxd(y_r) < 0) begin b_nxt = '0; f_nxt = 1'b1; end
              else if (sxd(y_r) > IW'(STACK_DEPTH - 1)) begin
                b_nxt = AW'(STACK_DEPTH - 1); f_nxt = 1'b1;
              end else b_nxt = y_r[AW-1:0];
            end else if (a_r == OPR_NEG) begin
              tgt = t0; wdata = ~x_r + 1'b1; wr_ok = 1'b1;
            end else if (a_r == OPR_ODD) begin
              tgt = t0; wr_ok = 1'b1;
              wdata = DATA_WIDTH'(!x_r[DATA_WIDTH-1] && x_r[0]);
            end else if ((a_r >= OPR_ADD && a_r <= OPR_DIV) || (a_r >= OPR_EQ && a_r <= OPR_LE)) begin
              tgt = t0 - 1; wdata = alu_res; wr_ok = 1'b1; newtop = t0 - 1;
            end
          end
        endcase
        if (wr_ok) begin
          if (inr(tgt)) begin we = 1'b1; addr = tgt[AW-1:0]; end
          else f_nxt = 1'b1;
        end
        if (op_r != OP_CAL) begin
          if (newtop < -1) begin t_nxt = -1; f_nxt = 1'b1; end
          else if (newtop > IW'(STACK_DEPTH - 1)) begin
            t_nxt = (AW+2)'(STACK_DEPTH - 1); f_nxt = 1'b1;
          end else t_nxt = (AW+2)'(newtop);
        end
      end
      S_WR2: begin
        tgt = (ph_r == 2'd0) ? t0 + 2 : t0 + 3;
        wdata = (ph_r == 2'd0) ? DATA_WIDTH'(b_r) : DATA_WIDTH'(pc_r);
        if (inr(tgt)) begin we = 1'b1; addr = tgt[AW-1:0]; end
        else f_nxt = 1'b1;
        if (ph_r == 2'd0) ph_nxt = 2'd1;
        else begin
          if (t0 + 1 > IW'(STACK_DEPTH - 1)) begin
            b_nxt = AW'(STACK_DEPTH - 1); f_nxt = 1'b1;
          end else if (t0 + 1 < 0) begin
            b_nxt = '0; f_nxt = 1'b1;
          end else b_nxt = AW'(t0 + 1);
          pc_nxt = a_r[PW-1:0];
          st_nxt = S_TOPRD;
        end
      end
      S_TOPRD: begin
        addr = t_r[AW-1:0];
        st_nxt = S_TOPW;
      end
      S_TOPW: begin
        r_nxt = (t_r < 0) ? '0 : rdata;
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || out_tready) begin
          od_nxt = '0;
          od_nxt[10:0] = 11'(pc_r);
          od_nxt[22:11] = 12'(b_r);
          od_nxt[35:23] = 13'(t_r);
          od_nxt[67:36] = 32'($signed(r_r));
          od_nxt[68] = (pc_r == '0);
          od_nxt[69] = f_r;
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; a_r <= a_nxt; lv_r <= lv_nxt; wb_r <= wb_nxt;
    x_r <= x_nxt; y_r <= y_nxt; r_r <= r_nxt; ph_r <= ph_nxt;
    od_r <= od_nxt;
    if (!rst_n) begin
      st_r <= S_CLEAR; pc_r <= '0; b_r <= '0; t_r <= -1;
      f_r <= 1'b0; ov_r <= 1'b0; clr_r <= '0;
    end else begin
      st_r <= st_nxt; pc_r <= pc_nxt; b_r <= b_nxt; t_r <= t_nxt;
      f_r <= f_nxt; ov_r <= ov_nxt; clr_r <= clr_nxt;
    end
  end
endmodule
`default_nettype wire
